/* hdl/scs_pkg.sv */
// Shared types, constants and lookup functions for the southbridge configuration space.
// Used by scs_ctrl, scs_datapath and southbridge_pci_config_space; depends on nothing.
package scs_pkg;

   localparam int RegSpace    = 256;
   localparam int NumFuncs    = 4;
   localparam int MemDepth    = RegSpace * NumFuncs;
   localparam int MemAw       = $clog2(MemDepth);
   localparam int DmaChannels = 8;
   localparam int DmaPageW    = 12;

   localparam logic [2:0] FUNC_BRIDGE = 3'd0;
   localparam logic [2:0] FUNC_IDE    = 3'd1;
   localparam logic [2:0] FUNC_USB    = 3'd2;
   localparam logic [2:0] FUNC_POWER  = 3'd3;

   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   localparam logic [7:0] BRIDGE_W1C   = 8'hb0;
   localparam logic [7:0] IDE_W1C      = 8'hf1;
   localparam logic [7:0] USB_W1C      = 8'h78;
   localparam logic [7:0] IDE_CMD_MASK = 8'h85;
   localparam logic [7:0] USB_CMD_MASK = 8'h97;
   localparam logic [7:0] IDE_PI_SET   = 8'h8a;
   localparam logic [7:0] RESET_BITS   = 8'h81;
   localparam logic [7:0] CTRL47_MASK  = 8'hfe;

   typedef struct packed {
      logic       req_type;
      logic [2:0] func_sel;
      logic [7:0] reg_addr;
      logic [7:0] wdata;
   } scs_req_type;

   typedef struct packed {
      logic [7:0] rdata;
      logic       write_ignored;
      logic       cpu_reset_req;
      logic       pic_shadow_on;
      logic       elcr_on;
   } scs_rsp_type;

   typedef struct packed {
      logic              init_we;
      logic [MemAw-1:0]  init_addr;
      logic              capture;
      logic              exec;
   } scs_cmd_type;

   function automatic logic [7:0] default_byte(input logic [MemAw-1:0] idx);
      logic [7:0] v;
      v = 8'h00;
      case (idx)
         10'h000: v = 8'h06; 10'h001: v = 8'h11; 10'h002: v = 8'h96; 10'h003: v = 8'h05;
         10'h004: v = 8'h0f; 10'h007: v = 8'h02; 10'h00a: v = 8'h01; 10'h00b: v = 8'h06;
         10'h00e: v = 8'h80; 10'h02c: v = 8'h73; 10'h02d: v = 8'h72; 10'h02e: v = 8'h71;
         10'h02f: v = 8'h70; 10'h048: v = 8'h01; 10'h04a: v = 8'h04; 10'h04f: v = 8'h03;
         10'h050: v = 8'h24; 10'h059: v = 8'h04;
         10'h100: v = 8'h06; 10'h101: v = 8'h11; 10'h102: v = 8'h71; 10'h103: v = 8'h05;
         10'h104: v = 8'h80; 10'h106: v = 8'h80; 10'h107: v = 8'h02; 10'h109: v = 8'h85;
         10'h10a: v = 8'h01; 10'h10b: v = 8'h01; 10'h110: v = 8'hf0; 10'h111: v = 8'h01;
         10'h114: v = 8'hf4; 10'h115: v = 8'h03; 10'h118: v = 8'h70; 10'h119: v = 8'h01;
         10'h11c: v = 8'h74; 10'h11d: v = 8'h03; 10'h120: v = 8'h01; 10'h121: v = 8'hcc;
         10'h13c: v = 8'h0e; 10'h140: v = 8'h08; 10'h141: v = 8'h02; 10'h142: v = 8'h09;
         10'h143: v = 8'h3a; 10'h144: v = 8'h68; 10'h146: v = 8'hc0; 10'h148: v = 8'ha8;
         10'h149: v = 8'ha8; 10'h14a: v = 8'ha8; 10'h14b: v = 8'ha8; 10'h14c: v = 8'hff;
         10'h14e: v = 8'hff; 10'h14f: v = 8'hff; 10'h150: v = 8'h03; 10'h151: v = 8'h03;
         10'h152: v = 8'h03; 10'h153: v = 8'h03; 10'h161: v = 8'h02; 10'h169: v = 8'h02;
         10'h200: v = 8'h06; 10'h201: v = 8'h11; 10'h202: v = 8'h38; 10'h203: v = 8'h30;
         10'h207: v = 8'h02; 10'h20a: v = 8'h03; 10'h20b: v = 8'h0c; 10'h20d: v = 8'h16;
         10'h220: v = 8'h01; 10'h221: v = 8'h03; 10'h23d: v = 8'h04; 10'h260: v = 8'h10;
         10'h2c1: v = 8'h20;
         10'h300: v = 8'h06; 10'h301: v = 8'h11; 10'h302: v = 8'h50; 10'h303: v = 8'h30;
         10'h306: v = 8'h80; 10'h307: v = 8'h02; 10'h348: v = 8'h01; 10'h390: v = 8'h01;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic logic bridge_ro(input logic [7:0] a);
      return a < 8'h04 || a == 8'h05 || (a >= 8'h08 && a < 8'h40) || a == 8'h49 ||
             a == 8'h4b || (a >= 8'h51 && a < 8'h54) || (a >= 8'h5d && a < 8'h60) ||
             (a >= 8'h68 && a < 8'h6a) || a >= 8'h73;
   endfunction

   function automatic logic ide_ro(input logic [7:0] a);
      return a < 8'h04 || a == 8'h05 || a == 8'h08 || (a >= 8'h0a && a < 8'h0d) ||
             (a >= 8'h0e && a < 8'h10) || a == 8'h12 || a == 8'h16 || a == 8'h1a ||
             a == 8'h1e || (a >= 8'h22 && a < 8'h3c) || (a >= 8'h3e && a < 8'h40) ||
             a >= 8'h52;
   endfunction

   function automatic logic usb_ro(input logic [7:0] a);
      return a < 8'h04 || a == 8'h05 || a == 8'h06 || (a >= 8'h08 && a < 8'h0d) ||
             (a >= 8'h0e && a < 8'h20) || (a >= 8'h22 && a < 8'h3c) ||
             (a >= 8'h3e && a < 8'h40) || (a >= 8'h42 && a < 8'h44) ||
             (a >= 8'h46 && a < 8'hc0) || a >= 8'hc2;
   endfunction

   function automatic logic power_ro(input logic [7:0] a);
      return a < 8'h0d || (a >= 8'h0e && a < 8'h40) || a == 8'h43 || a == 8'h48 ||
             (a >= 8'h4a && a < 8'h50) || a >= 8'h54;
   endfunction

endpackage

/* hdl/scs_ctrl.sv */
// Control state machine: initialization sweep, request capture, execute and response hold.
// Depends on scs_pkg for the command struct and memory address width.
module scs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output scs_pkg::scs_cmd_type cmd
);

   localparam logic [1:0] ST_INIT = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [scs_pkg::MemAw-1:0] sweep_ff, sweep_in;

   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      unique case (state_ff)
         ST_INIT: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == {scs_pkg::MemAw{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = (state_ff == ST_RESP);
   assign cmd.init_we   = (state_ff == ST_INIT);
   assign cmd.init_addr = sweep_ff;
   assign cmd.capture   = (state_ff == ST_IDLE) && req_valid;
   assign cmd.exec      = (state_ff == ST_EXEC);

endmodule

/* hdl/scs_datapath.sv */
// Datapath: register file memory, DMA page registers, control flags and write decode.
// Depends on scs_pkg for types, default table and read-only range functions.
module scs_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  scs_pkg::scs_cmd_type cmd,
   input  scs_pkg::scs_req_type req_payload,
   output scs_pkg::scs_rsp_type rsp_payload
);

   logic [7:0] mem [scs_pkg::MemDepth];
   logic [7:0] rd_ff;

   scs_pkg::scs_req_type req_ff;
   scs_pkg::scs_rsp_type rsp_ff, rsp_in;

   logic [scs_pkg::DmaPageW-1:0]    page_ff [scs_pkg::DmaChannels];
   logic [scs_pkg::DmaPageW-1:0]    page_in;
   logic [scs_pkg::DmaChannels-1:0] en_ff, en_in;
   logic                            pic_ff, pic_in, elcr_ff, elcr_in;
   logic                            page_we;

   logic                      wr_we;
   logic [7:0]                wr_offs;
   logic [7:0]                wr_data;
   logic                      mem_we;
   logic [scs_pkg::MemAw-1:0] mem_waddr;
   logic [7:0]                mem_wdata;

   logic [2:0] f;
   logic [7:0] a, v;
   logic [2:0] ch;
   logic       is_dma;

   assign f      = req_ff.func_sel;
   assign a      = req_ff.reg_addr;
   assign v      = req_ff.wdata;
   assign ch     = a[3:1];
   assign is_dma = (a >= 8'h60) && (a <= 8'h6f);

   always_comb begin
      rsp_in  = '0;
      wr_we   = 1'b0;
      wr_offs = a;
      wr_data = v;
      page_we = 1'b0;
      page_in = page_ff[ch];
      en_in   = en_ff;
      pic_in  = pic_ff;
      elcr_in = elcr_ff;
      if (req_ff.req_type == scs_pkg::REQ_READ) begin
         if (f > scs_pkg::FUNC_POWER) begin
            rsp_in.rdata = 8'hff;
         end else if (f == scs_pkg::FUNC_BRIDGE && is_dma) begin
            if (a[0]) begin
               rsp_in.rdata = page_ff[ch][11:4];
            end else begin
               rsp_in.rdata = {page_ff[ch][3:0], en_ff[ch], 3'b000};
            end
         end else begin
            rsp_in.rdata = rd_ff;
         end
      end else begin
         unique case (f)
            scs_pkg::FUNC_BRIDGE: begin
               if (scs_pkg::bridge_ro(a)) begin
                  rsp_in.write_ignored = 1'b1;
               end else if (is_dma) begin
                  page_we = 1'b1;
                  if (a[0]) begin
                     page_in = {v, page_ff[ch][3:0]};
                  end else begin
                     page_in    = {page_ff[ch][11:4], v[7:4]};
                     en_in[ch]  = v[3];
                  end
               end else begin
                  unique case (a)
                     8'h04: begin
                        wr_we   = 1'b1;
                        wr_data = (v & 8'h08) | 8'h07;
                     end
                     8'h07: begin
                        wr_we   = 1'b1;
                        wr_data = rd_ff & ~(v & scs_pkg::BRIDGE_W1C);
                     end
                     8'h47: begin
                        wr_we   = 1'b1;
                        wr_data = v & scs_pkg::CTRL47_MASK;
                        pic_in  = v[4];
                        elcr_in = v[5];
                        rsp_in.cpu_reset_req =
                           ((v & scs_pkg::RESET_BITS) == scs_pkg::RESET_BITS);
                     end
                     8'h48, 8'h55, 8'h56, 8'h57, 8'h58, 8'h5b: wr_we = 1'b1;
                     8'h70, 8'h71, 8'h72: begin
                        wr_we   = 1'b1;
                        wr_offs = a - 8'h44;
                     end
                     default: wr_we = 1'b0;
                  endcase
               end
            end
            scs_pkg::FUNC_IDE: begin
               if (scs_pkg::ide_ro(a)) begin
                  rsp_in.write_ignored = 1'b1;
               end else begin
                  wr_we = 1'b1;
                  unique case (a)
                     8'h04: wr_data = v & scs_pkg::IDE_CMD_MASK;
                     8'h07: wr_data = rd_ff & ~(v & scs_pkg::IDE_W1C);
                     8'h09: wr_data = (v & 8'h05) | scs_pkg::IDE_PI_SET;
                     8'h10, 8'h18: wr_data = (v & 8'hf8) | 8'h01;
                     8'h14, 8'h1c: wr_data = (v & 8'hfc) | 8'h01;
                     8'h20: wr_data = (v & 8'hf0) | 8'h01;
                     8'h3d: wr_data = v & 8'h01;
                     default: wr_data = v;
                  endcase
               end
            end
            scs_pkg::FUNC_USB: begin
               if (scs_pkg::usb_ro(a)) begin
                  rsp_in.write_ignored = 1'b1;
               end else begin
                  wr_we = 1'b1;
                  unique case (a)
                     8'h04: wr_data = v & scs_pkg::USB_CMD_MASK;
                     8'h07: wr_data = rd_ff & ~(v & scs_pkg::USB_W1C);
                     8'h20: wr_data = (v & 8'he0) | 8'h01;
                     default: wr_data = v;
                  endcase
               end
            end
            scs_pkg::FUNC_POWER: begin
               if (scs_pkg::power_ro(a)) begin
                  rsp_in.write_ignored = 1'b1;
               end else begin
                  wr_we = 1'b1;
               end
            end
            default: rsp_in.write_ignored = 1'b1;
         endcase
      end
      rsp_in.pic_shadow_on = pic_in;
      rsp_in.elcr_on       = elcr_in;
   end

   always_comb begin
      if (cmd.init_we) begin
         mem_we    = 1'b1;
         mem_waddr = cmd.init_addr;
         mem_wdata = scs_pkg::default_byte(cmd.init_addr);
      end else begin
         mem_we    = cmd.exec && wr_we;
         mem_waddr = {f[1:0], wr_offs};
         mem_wdata = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= mem[{req_payload.func_sel[1:0], req_payload.reg_addr}];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < scs_pkg::DmaChannels; i++) begin
            page_ff[i] <= '0;
         end
         en_ff   <= '0;
         pic_ff  <= 1'b0;
         elcr_ff <= 1'b0;
      end else if (cmd.exec) begin
         if (page_we) begin
            page_ff[ch] <= page_in;
         end
         en_ff   <= en_in;
         pic_ff  <= pic_in;
         elcr_ff <= elcr_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

/* hdl/southbridge_pci_config_space.sv */
// A request is taken in the idle state, executed in the exec state after it, and its response is
// valid from the response state on; one request is in flight at a time, as the controller
// waits in its response state until the response is taken before it accepts the next request.
// After reset the block loads the default tables into all 1024 register file entries and
// holds req_stall high during that sweep. Depends on scs_pkg, scs_ctrl and scs_datapath.
module southbridge_pci_config_space (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  scs_pkg::scs_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output scs_pkg::scs_rsp_type rsp_payload
);

   // Commands from the controller steer the datapath; nothing else joins the two.
   scs_pkg::scs_cmd_type cmd;

   // The controller owns the handshakes: it accepts a transfer only when idle and
   // holds the response until the consumer takes the transfer.
   scs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // The datapath holds the register file, the DMA page fields and the flags, and
   // registers the response so it stays stable while stalled.
   scs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule
